// ===== sv/imu_midpoint_preintegration_assert.svh =====
// assertion macros for the imu pre-integration block
`ifndef IMU_MIDPOINT_PREINTEGRATION_ASSERT_SVH
`define IMU_MIDPOINT_PREINTEGRATION_ASSERT_SVH
`ifndef SYNTHESIS
`define IMP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IMP_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IMP_ASSERT(lbl, clk, rst, prop, msg)
`define IMP_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/imp_pkg.sv =====
// shared types, constants and helpers for the imu pre-integration block
package imp_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int ACC_W = 56;
   localparam int MUL_W = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int STEP_W = 7;

   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   localparam logic [2:0] CSR_ACC_BIAS_X = 3'd0;
   localparam logic [2:0] CSR_ACC_BIAS_Y = 3'd1;
   localparam logic [2:0] CSR_ACC_BIAS_Z = 3'd2;
   localparam logic [2:0] CSR_GYRO_BIAS_X = 3'd3;
   localparam logic [2:0] CSR_GYRO_BIAS_Y = 3'd4;
   localparam logic [2:0] CSR_GYRO_BIAS_Z = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      SH_0,
      SH_11,
      SH_24,
      SH_25,
      SH_26,
      SH_30
   } sh_type;

   typedef enum logic [3:0] {
      D_NONE,
      D_G,
      D_H,
      D_DT2,
      D_NQ,
      D_UA,
      D_UB,
      D_T,
      D_SA,
      D_SB,
      D_POS,
      D_VEL
   } dst_type;

   typedef struct packed {
      logic   acc_en;
      logic   first;
      logic   neg;
      sh_type sh;
   } mac_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [31:0] r;
      if (&x[ACC_W-1:31] || ~|x[ACC_W-1:31]) begin
         r = x[31:0];
      end else if (x[ACC_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

// ===== sv/imp_if.sv =====
// handshake channels of the imu pre-integration block
interface imp_req_if;
   logic               valid;
   logic               ready;
   logic               new_window;
   logic [23:0]        step_time;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [31:0] acc_z;
   logic signed [31:0] rate_x;
   logic signed [31:0] rate_y;
   logic signed [31:0] rate_z;
   modport source(output valid, new_window, step_time, acc_x, acc_y, acc_z,
                  rate_x, rate_y, rate_z, input ready);
   modport sink(input valid, new_window, step_time, acc_x, acc_y, acc_z,
                rate_x, rate_y, rate_z, output ready);
endinterface

interface imp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] rot_w;
   logic signed [31:0] rot_x;
   logic signed [31:0] rot_y;
   logic signed [31:0] rot_z;
   modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  rot_w, rot_x, rot_y, rot_z, input ready);
   modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                rot_w, rot_x, rot_y, rot_z, output ready);
endinterface

interface imp_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [31:0] data;
   modport source(output valid, addr, data, input ready);
   modport sink(input valid, addr, data, output ready);
endinterface

// ===== sv/imp_mac.sv =====
// shared multiply, floor shift and accumulate unit
module imp_mac (
   input  logic                                clock,
   input  imp_pkg::mac_ctl_type                ctl,
   input  logic signed [imp_pkg::MUL_W-1:0]    op_a,
   input  logic signed [imp_pkg::MUL_W-1:0]    op_b,
   input  logic signed [imp_pkg::ACC_W-1:0]    op_init,
   output logic signed [imp_pkg::ACC_W-1:0]    acc_sum
);

   localparam int AW = imp_pkg::ACC_W;
   localparam int PW = imp_pkg::PROD_W;

   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [PW-1:0] shifted;
   logic signed [AW-1:0] term;
   logic signed [AW-1:0] base;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctl.acc_en) begin
         acc_ff <= acc_sum;
      end
   end

   // arithmetic shift gives the floor of the scaled product
   always_comb begin
      case (ctl.sh)
         imp_pkg::SH_0:  shifted = prod_ff;
         imp_pkg::SH_11: shifted = prod_ff >>> 11;
         imp_pkg::SH_24: shifted = prod_ff >>> 24;
         imp_pkg::SH_25: shifted = prod_ff >>> 25;
         imp_pkg::SH_26: shifted = prod_ff >>> 26;
         imp_pkg::SH_30: shifted = prod_ff >>> 30;
         default:        shifted = prod_ff;
      endcase
      term = ctl.neg ? -shifted[AW-1:0] : shifted[AW-1:0];
      base = ctl.first ? op_init : acc_ff;
      acc_sum = base + term;
   end

endmodule

// ===== sv/imu_midpoint_preintegration.sv =====
// imu midpoint pre-integration: sequencer, state and shared mac unit
//
//   channel  dir  fields
//   req_ch   in   new_window, step_time, acc_x/y/z, rate_x/y/z
//   rsp_ch   out  pos_x/y/z, vel_x/y/z, rot_w/x/y/z
//   csr_ch   in   addr (0..5 bias registers), data
//
// an integrating sample runs 67 mac steps in ST_RUN, then waits in ST_DONE until
// rsp_ch is free to load its result, and req_ch is ready again in ST_IDLE after that
// a window restart or the first sample after reset skips the mac steps and goes to ST_DONE
// the single multiplier in imp_mac is shared by all steps; req_ch is not ready outside ST_IDLE
// reset is synchronous and gives the identity window with zero biases
// a stalled rsp_ch holds the finished sample until its register is free
module imu_midpoint_preintegration #(
   parameter int DATA_WIDTH = imp_pkg::DATA_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   imp_req_if.sink   req_ch,
   imp_rsp_if.source rsp_ch,
   imp_csr_if.sink   csr_ch
);

`include "imu_midpoint_preintegration_assert.svh"

   localparam int AW = imp_pkg::ACC_W;
   localparam int MW = imp_pkg::MUL_W;
   localparam int SW = imp_pkg::STEP_W;

   localparam logic [SW-1:0] S_H    = SW'(3);
   localparam logic [SW-1:0] S_DT2  = SW'(6);
   localparam logic [SW-1:0] S_NQ   = SW'(7);
   localparam logic [SW-1:0] S_UA   = SW'(19);
   localparam logic [SW-1:0] S_UB   = SW'(22);
   localparam logic [SW-1:0] S_ROTA = SW'(25);
   localparam logic [SW-1:0] S_ROTB = SW'(40);
   localparam logic [SW-1:0] S_AX   = SW'(55);
   localparam logic [SW-1:0] S_LAST = SW'(66);

   imp_pkg::state_type state_ff, state_in;
   logic [SW-1:0]      step_ff, step_in;
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff;
   logic               have_ff;
   logic               clr_ff;

   logic signed [31:0] acc_bias_ff [3];
   logic signed [31:0] gyro_bias_ff [3];
   logic signed [DATA_WIDTH-1:0] pos_ff [3];
   logic signed [DATA_WIDTH-1:0] vel_ff [3];
   logic signed [31:0] rot_ff [4];
   logic signed [31:0] last_acc_ff [3];
   logic signed [31:0] last_rate_ff [3];

   logic [23:0]        dt_ff;
   logic signed [31:0] cur_acc_ff [3];
   logic signed [31:0] cur_rate_ff [3];

   logic signed [MW-1:0] h_ff [3];
   logic signed [31:0]   nq_ff [4];
   logic signed [31:0]   ua_ff [3];
   logic signed [31:0]   ub_ff [3];
   logic signed [31:0]   t_ff [3];
   logic signed [32:0]   s_ff [3];
   logic [23:0]          dt2_ff;

   logic signed [31:0] out_pos_ff [3];
   logic signed [31:0] out_vel_ff [3];
   logic signed [31:0] out_rot_ff [4];

   imp_pkg::mac_ctl_type ctl;
   imp_pkg::dst_type     dst;
   logic [1:0]           dst_idx;
   logic signed [MW-1:0] op_a, op_b;
   logic signed [AW-1:0] op_init;
   logic signed [AW-1:0] acc_sum;
   logic signed [MW-1:0] dt_op, dt2_op;
   logic [SW-1:0]        sub;
   logic [1:0]           i2;
   logic                 rot_pass;
   logic signed [31:0]   rq [4];
   logic signed [31:0]   rv [3];
   logic signed [AW-1:0] vel_ext;
   imp_pkg::dst_type     rdst;
   logic                 req_fire, rsp_free, commit;

   function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [AW-1:0] x);
      logic signed [DATA_WIDTH-1:0] r;
      if (&x[AW-1:DATA_WIDTH-1] || ~|x[AW-1:DATA_WIDTH-1]) begin
         r = x[DATA_WIDTH-1:0];
      end else if (x[AW-1]) begin
         r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   assign req_ch.ready = (state_ff == imp_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign commit       = (state_ff == imp_pkg::ST_DONE) && rsp_free;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.pos_x = out_pos_ff[0];
   assign rsp_ch.pos_y = out_pos_ff[1];
   assign rsp_ch.pos_z = out_pos_ff[2];
   assign rsp_ch.vel_x = out_vel_ff[0];
   assign rsp_ch.vel_y = out_vel_ff[1];
   assign rsp_ch.vel_z = out_vel_ff[2];
   assign rsp_ch.rot_w = out_rot_ff[0];
   assign rsp_ch.rot_x = out_rot_ff[1];
   assign rsp_ch.rot_y = out_rot_ff[2];
   assign rsp_ch.rot_z = out_rot_ff[3];

   assign dt_op  = MW'(signed'({1'b0, dt_ff}));
   assign dt2_op = MW'(signed'({1'b0, dt2_ff}));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imp_pkg::ST_IDLE;
         step_ff  <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      case (state_ff)
         imp_pkg::ST_IDLE: begin
            step_in  = '0;
            phase_in = 1'b0;
            if (req_fire) begin
               state_in = (req_ch.new_window || !have_ff) ? imp_pkg::ST_DONE : imp_pkg::ST_RUN;
            end
         end
         imp_pkg::ST_RUN: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (step_ff == S_LAST) begin
                  step_in  = '0;
                  state_in = imp_pkg::ST_DONE;
               end else begin
                  step_in = step_ff + SW'(1);
               end
            end
         end
         imp_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = imp_pkg::ST_IDLE;
            end
         end
         default: state_in = imp_pkg::ST_IDLE;
      endcase
   end

   // step decode: operands, shift, sign and write-back target
   always_comb begin
      ctl.acc_en = (state_ff == imp_pkg::ST_RUN) && phase_ff;
      ctl.first  = 1'b0;
      ctl.neg    = 1'b0;
      ctl.sh     = imp_pkg::SH_0;
      op_a       = '0;
      op_b       = '0;
      op_init    = '0;
      dst        = imp_pkg::D_NONE;
      dst_idx    = '0;
      sub        = '0;
      i2         = '0;
      rot_pass   = (step_ff >= S_ROTB);
      for (int k = 0; k < 4; k++) begin
         rq[k] = rot_pass ? nq_ff[k] : rot_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         rv[k] = rot_pass ? ub_ff[k] : ua_ff[k];
      end
      rdst    = rot_pass ? imp_pkg::D_SB : imp_pkg::D_SA;
      vel_ext = '0;

      if (step_ff < S_H) begin
         // mean gyro rate minus bias
         i2         = step_ff[1:0];
         ctl.first  = 1'b1;
         op_init    = ((AW'(last_rate_ff[i2]) + AW'(cur_rate_ff[i2])) >>> 1)
                      - AW'(gyro_bias_ff[i2]);
         dst        = imp_pkg::D_G;
         dst_idx    = i2;
      end else if (step_ff < S_DT2) begin
         sub       = step_ff - S_H;
         i2        = sub[1:0];
         ctl.first = 1'b1;
         op_a      = h_ff[i2];
         op_b      = dt_op;
         ctl.sh    = imp_pkg::SH_11;
         dst       = imp_pkg::D_H;
         dst_idx   = i2;
      end else if (step_ff < S_NQ) begin
         ctl.first = 1'b1;
         op_a      = dt_op;
         op_b      = dt_op;
         ctl.sh    = imp_pkg::SH_24;
         dst       = imp_pkg::D_DT2;
      end else if (step_ff < S_UA) begin
         // first-order quaternion product with (1, h)
         sub    = step_ff - S_NQ;
         ctl.sh = imp_pkg::SH_30;
         case (sub[3:0])
            4'd0: begin
               ctl.first = 1'b1; op_init = AW'(rot_ff[0]); ctl.neg = 1'b1;
               op_a = MW'(rot_ff[1]); op_b = h_ff[0];
            end
            4'd1: begin
               ctl.neg = 1'b1; op_a = MW'(rot_ff[2]); op_b = h_ff[1];
            end
            4'd2: begin
               ctl.neg = 1'b1; op_a = MW'(rot_ff[3]); op_b = h_ff[2];
               dst = imp_pkg::D_NQ; dst_idx = 2'd0;
            end
            4'd3: begin
               ctl.first = 1'b1; op_init = AW'(rot_ff[1]);
               op_a = MW'(rot_ff[0]); op_b = h_ff[0];
            end
            4'd4: begin
               op_a = MW'(rot_ff[2]); op_b = h_ff[2];
            end
            4'd5: begin
               ctl.neg = 1'b1; op_a = MW'(rot_ff[3]); op_b = h_ff[1];
               dst = imp_pkg::D_NQ; dst_idx = 2'd1;
            end
            4'd6: begin
               ctl.first = 1'b1; op_init = AW'(rot_ff[2]);
               op_a = MW'(rot_ff[0]); op_b = h_ff[1];
            end
            4'd7: begin
               ctl.neg = 1'b1; op_a = MW'(rot_ff[1]); op_b = h_ff[2];
            end
            4'd8: begin
               op_a = MW'(rot_ff[3]); op_b = h_ff[0];
               dst = imp_pkg::D_NQ; dst_idx = 2'd2;
            end
            4'd9: begin
               ctl.first = 1'b1; op_init = AW'(rot_ff[3]);
               op_a = MW'(rot_ff[0]); op_b = h_ff[2];
            end
            4'd10: begin
               op_a = MW'(rot_ff[1]); op_b = h_ff[1];
            end
            4'd11: begin
               ctl.neg = 1'b1; op_a = MW'(rot_ff[2]); op_b = h_ff[0];
               dst = imp_pkg::D_NQ; dst_idx = 2'd3;
            end
            default: ;
         endcase
      end else if (step_ff < S_UB) begin
         sub       = step_ff - S_UA;
         i2        = sub[1:0];
         ctl.first = 1'b1;
         op_init   = AW'(last_acc_ff[i2]) - AW'(acc_bias_ff[i2]);
         dst       = imp_pkg::D_UA;
         dst_idx   = i2;
      end else if (step_ff < S_ROTA) begin
         sub       = step_ff - S_UB;
         i2        = sub[1:0];
         ctl.first = 1'b1;
         op_init   = AW'(cur_acc_ff[i2]) - AW'(acc_bias_ff[i2]);
         dst       = imp_pkg::D_UB;
         dst_idx   = i2;
      end else if (step_ff < S_AX) begin
         // rotate v by q: v + q0*t + u x t with t = 2 (u x v)
         sub    = rot_pass ? (step_ff - S_ROTB) : (step_ff - S_ROTA);
         ctl.sh = imp_pkg::SH_30;
         case (sub[3:0])
            4'd0: begin
               ctl.first = 1'b1; op_a = MW'(rq[2]); op_b = MW'(rv[2]);
            end
            4'd1: begin
               ctl.neg = 1'b1; op_a = MW'(rq[3]); op_b = MW'(rv[1]);
               dst = imp_pkg::D_T; dst_idx = 2'd0;
            end
            4'd2: begin
               ctl.first = 1'b1; op_a = MW'(rq[3]); op_b = MW'(rv[0]);
            end
            4'd3: begin
               ctl.neg = 1'b1; op_a = MW'(rq[1]); op_b = MW'(rv[2]);
               dst = imp_pkg::D_T; dst_idx = 2'd1;
            end
            4'd4: begin
               ctl.first = 1'b1; op_a = MW'(rq[1]); op_b = MW'(rv[1]);
            end
            4'd5: begin
               ctl.neg = 1'b1; op_a = MW'(rq[2]); op_b = MW'(rv[0]);
               dst = imp_pkg::D_T; dst_idx = 2'd2;
            end
            4'd6: begin
               ctl.first = 1'b1; op_init = AW'(rv[0]);
               op_a = MW'(rq[0]); op_b = MW'(t_ff[0]);
            end
            4'd7: begin
               op_a = MW'(rq[2]); op_b = MW'(t_ff[2]);
            end
            4'd8: begin
               ctl.neg = 1'b1; op_a = MW'(rq[3]); op_b = MW'(t_ff[1]);
               dst = rdst; dst_idx = 2'd0;
            end
            4'd9: begin
               ctl.first = 1'b1; op_init = AW'(rv[1]);
               op_a = MW'(rq[0]); op_b = MW'(t_ff[1]);
            end
            4'd10: begin
               op_a = MW'(rq[3]); op_b = MW'(t_ff[0]);
            end
            4'd11: begin
               ctl.neg = 1'b1; op_a = MW'(rq[1]); op_b = MW'(t_ff[2]);
               dst = rdst; dst_idx = 2'd1;
            end
            4'd12: begin
               ctl.first = 1'b1; op_init = AW'(rv[2]);
               op_a = MW'(rq[0]); op_b = MW'(t_ff[2]);
            end
            4'd13: begin
               op_a = MW'(rq[1]); op_b = MW'(t_ff[1]);
            end
            4'd14: begin
               ctl.neg = 1'b1; op_a = MW'(rq[2]); op_b = MW'(t_ff[0]);
               dst = rdst; dst_idx = 2'd2;
            end
            default: ;
         endcase
      end else begin
         // per axis: position then velocity
         sub     = step_ff - S_AX;
         i2      = sub[3:2];
         dst_idx = i2;
         vel_ext = AW'(vel_ff[i2]);
         case (sub[1:0])
            2'd0: begin
               ctl.first = 1'b1; op_init = AW'(pos_ff[i2]);
               op_a = MW'(vel_ext >>> 24); op_b = dt_op;
            end
            2'd1: begin
               op_a = MW'(signed'({1'b0, vel_ext[23:0]})); op_b = dt_op;
               ctl.sh = imp_pkg::SH_24;
            end
            2'd2: begin
               op_a = dt2_op; op_b = MW'(s_ff[i2]);
               ctl.sh = imp_pkg::SH_26; dst = imp_pkg::D_POS;
            end
            2'd3: begin
               ctl.first = 1'b1; op_init = AW'(vel_ff[i2]);
               op_a = dt_op; op_b = MW'(s_ff[i2]);
               ctl.sh = imp_pkg::SH_25; dst = imp_pkg::D_VEL;
            end
            default: ;
         endcase
      end
   end

   imp_mac u_mac (
      .clock   (clock),
      .ctl     (ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .op_init (op_init),
      .acc_sum (acc_sum)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            acc_bias_ff[k]  <= '0;
            gyro_bias_ff[k] <= '0;
         end
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.addr)
            imp_pkg::CSR_ACC_BIAS_X:  acc_bias_ff[0]  <= csr_ch.data;
            imp_pkg::CSR_ACC_BIAS_Y:  acc_bias_ff[1]  <= csr_ch.data;
            imp_pkg::CSR_ACC_BIAS_Z:  acc_bias_ff[2]  <= csr_ch.data;
            imp_pkg::CSR_GYRO_BIAS_X: gyro_bias_ff[0] <= csr_ch.data;
            imp_pkg::CSR_GYRO_BIAS_Y: gyro_bias_ff[1] <= csr_ch.data;
            imp_pkg::CSR_GYRO_BIAS_Z: gyro_bias_ff[2] <= csr_ch.data;
            default: ;
         endcase
      end
   end

   // sample capture, scratch write-back and output load
   always_ff @(posedge clock) begin
      if (req_fire) begin
         clr_ff         <= req_ch.new_window || !have_ff;
         dt_ff          <= req_ch.step_time;
         cur_acc_ff[0]  <= req_ch.acc_x;
         cur_acc_ff[1]  <= req_ch.acc_y;
         cur_acc_ff[2]  <= req_ch.acc_z;
         cur_rate_ff[0] <= req_ch.rate_x;
         cur_rate_ff[1] <= req_ch.rate_y;
         cur_rate_ff[2] <= req_ch.rate_z;
      end
      if (ctl.acc_en) begin
         case (dst)
            imp_pkg::D_G:   h_ff[dst_idx]  <= acc_sum[MW-1:0];
            imp_pkg::D_H:   h_ff[dst_idx]  <= MW'(imp_pkg::sat32(acc_sum));
            imp_pkg::D_DT2: dt2_ff         <= acc_sum[23:0];
            imp_pkg::D_NQ:  nq_ff[dst_idx] <= imp_pkg::sat32(acc_sum);
            imp_pkg::D_UA:  ua_ff[dst_idx] <= imp_pkg::sat32(acc_sum);
            imp_pkg::D_UB:  ub_ff[dst_idx] <= imp_pkg::sat32(acc_sum);
            imp_pkg::D_T:   t_ff[dst_idx]  <= imp_pkg::sat32({acc_sum[AW-2:0], 1'b0});
            imp_pkg::D_SA:  s_ff[dst_idx]  <= 33'(imp_pkg::sat32(acc_sum));
            imp_pkg::D_SB:  s_ff[dst_idx]  <= s_ff[dst_idx] + 33'(imp_pkg::sat32(acc_sum));
            default: ;
         endcase
      end
      if (commit) begin
         for (int k = 0; k < 3; k++) begin
            out_pos_ff[k] <= clr_ff ? '0 : imp_pkg::sat32(AW'(pos_ff[k]));
            out_vel_ff[k] <= clr_ff ? '0 : imp_pkg::sat32(AW'(vel_ff[k]));
         end
         out_rot_ff[0] <= clr_ff ? imp_pkg::Q30_ONE : nq_ff[0];
         for (int k = 1; k < 4; k++) begin
            out_rot_ff[k] <= clr_ff ? '0 : nq_ff[k];
         end
      end
   end

   // window state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         have_ff      <= 1'b0;
         rot_ff[0]    <= imp_pkg::Q30_ONE;
         for (int k = 1; k < 4; k++) begin
            rot_ff[k] <= '0;
         end
         for (int k = 0; k < 3; k++) begin
            pos_ff[k]       <= '0;
            vel_ff[k]       <= '0;
            last_acc_ff[k]  <= '0;
            last_rate_ff[k] <= '0;
         end
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.acc_en && dst == imp_pkg::D_POS) begin
            pos_ff[dst_idx] <= sat_dw(acc_sum);
         end
         if (ctl.acc_en && dst == imp_pkg::D_VEL) begin
            vel_ff[dst_idx] <= sat_dw(acc_sum);
         end
         if (commit) begin
            have_ff <= 1'b1;
            for (int k = 0; k < 3; k++) begin
               last_acc_ff[k]  <= cur_acc_ff[k];
               last_rate_ff[k] <= cur_rate_ff[k];
            end
            if (clr_ff) begin
               rot_ff[0] <= imp_pkg::Q30_ONE;
               for (int k = 1; k < 4; k++) begin
                  rot_ff[k] <= '0;
               end
               for (int k = 0; k < 3; k++) begin
                  pos_ff[k] <= '0;
                  vel_ff[k] <= '0;
               end
            end else begin
               for (int k = 0; k < 4; k++) begin
                  rot_ff[k] <= nq_ff[k];
               end
            end
         end
      end
   end

   `IMP_ASSERT(a_busy_after_beat, clock, reset, req_fire |=> !req_ch.ready, "accepted a beat while busy")
   `IMP_ASSERT(a_step_idle, clock, reset, state_ff != imp_pkg::ST_RUN |-> (step_ff == '0 && !phase_ff), "step counter left running")
   `IMP_ASSERT(a_last_done, clock, reset, (state_ff == imp_pkg::ST_RUN && phase_ff && step_ff == S_LAST) |=> state_ff == imp_pkg::ST_DONE, "sequence did not finish")
   `IMP_ASSERT_NR(a_reset_clean, clock, reset |=> (state_ff == imp_pkg::ST_IDLE && !rsp_ch.valid), "reset left block busy")

endmodule
